// File: hdl/lpa_pkg.sv
// lpa_pkg: shared types, constants and the arctangent table for line_pair_angle
// no dependencies; used by every module of the block
`default_nettype none

package lpa_pkg;

    // defaults of the top-level parameters
    localparam int COEF_WIDTH_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRAC_BITS_DEF     = 8;

    // result field width, fixed by the output format
    localparam int ANGLE_W  = 15;
    // angle accumulator counts degrees * 2^ANG_FRAC
    localparam int ANG_FRAC = 20;
    // normalized magnitudes lie in [2^29, 2^30)
    localparam int NORM_W   = 30;
    // cordic x/y datapath, signed, with headroom for the gain
    localparam int CX_W     = 34;
    // signed angle accumulator
    localparam int Z_W      = 29;

    typedef enum logic [1:0] {
        KIND_NORMAL,
        KIND_DEGEN,
        KIND_PARALLEL,
        KIND_PERP
    } t_kind;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_tag;

    // atan(2^-idx) in degrees * 2^20, rounded to nearest
    function automatic logic [25:0] atan_deg(input logic [4:0] idx);
        logic [25:0] v;
        case (idx)
            5'd0:    v = 26'd47185920;
            5'd1:    v = 26'd27855475;
            5'd2:    v = 26'd14718068;
            5'd3:    v = 26'd7471121;
            5'd4:    v = 26'd3750058;
            5'd5:    v = 26'd1876857;
            5'd6:    v = 26'd938658;
            5'd7:    v = 26'd469357;
            5'd8:    v = 26'd234682;
            5'd9:    v = 26'd117342;
            5'd10:   v = 26'd58671;
            5'd11:   v = 26'd29335;
            5'd12:   v = 26'd14668;
            5'd13:   v = 26'd7334;
            5'd14:   v = 26'd3667;
            5'd15:   v = 26'd1833;
            5'd16:   v = 26'd917;
            5'd17:   v = 26'd458;
            5'd18:   v = 26'd229;
            5'd19:   v = 26'd115;
            5'd20:   v = 26'd57;
            5'd21:   v = 26'd29;
            5'd22:   v = 26'd14;
            5'd23:   v = 26'd7;
            5'd24:   v = 26'd4;
            5'd25:   v = 26'd2;
            5'd26:   v = 26'd1;
            default: v = 26'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hdl/lpa_terms.sv
// lpa_terms: products, cross/dot terms and their magnitudes in three stages
// depends on lpa_pkg
`default_nettype none

module lpa_terms #(
    parameter int COEF_WIDTH = lpa_pkg::COEF_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire logic signed [COEF_WIDTH-1:0]   i_first_x_coef,
    input  wire logic signed [COEF_WIDTH-1:0]   i_first_y_coef,
    input  wire logic signed [COEF_WIDTH-1:0]   i_second_x_coef,
    input  wire logic signed [COEF_WIDTH-1:0]   i_second_y_coef,
    output lpa_pkg::t_tag                       o_tag,
    output logic             [2*COEF_WIDTH-1:0] o_x_mag,
    output logic             [2*COEF_WIDTH-1:0] o_y_mag
);

    localparam int PW = 2 * COEF_WIDTH;
    localparam int SW = 2 * COEF_WIDTH + 1;

    logic signed [PW-1:0] n_a1a2, n_b1b2, n_a2b1, n_a1b2;
    logic signed [PW-1:0] r_a1a2, r_b1b2, r_a2b1, r_a1b2;
    logic                 n_degen;
    lpa_pkg::t_tag        r_tag1, r_tag2, r_tag3, n_tag3;
    logic signed [SW-1:0] n_cross, n_dot, r_cross, r_dot;
    logic        [PW-1:0] n_xm, n_ym, r_xm, r_ym;

    assign n_a1a2 = i_first_x_coef * i_second_x_coef;
    assign n_b1b2 = i_first_y_coef * i_second_y_coef;
    assign n_a2b1 = i_second_x_coef * i_first_y_coef;
    assign n_a1b2 = i_first_x_coef * i_second_y_coef;

    assign n_degen = ((i_first_x_coef == '0) && (i_first_y_coef == '0)) ||
                     ((i_second_x_coef == '0) && (i_second_y_coef == '0));

    assign n_cross = SW'(r_a2b1) - SW'(r_a1b2);
    assign n_dot   = SW'(r_a1a2) + SW'(r_b1b2);

    assign n_xm = r_dot[SW-1]   ? PW'(-r_dot)   : PW'(r_dot);
    assign n_ym = r_cross[SW-1] ? PW'(-r_cross) : PW'(r_cross);

    // zero cross term wins over zero dot term
    always_comb begin
        n_tag3 = r_tag2;
        if (r_tag2.kind == lpa_pkg::KIND_NORMAL) begin
            if (r_cross == '0) begin
                n_tag3.kind = lpa_pkg::KIND_PARALLEL;
            end else if (r_dot == '0) begin
                n_tag3.kind = lpa_pkg::KIND_PERP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
            r_tag2.valid <= 1'b0;
            r_tag3.valid <= 1'b0;
        end else if (i_en) begin
            r_tag1.valid <= i_valid;
            r_tag1.kind  <= n_degen ? lpa_pkg::KIND_DEGEN : lpa_pkg::KIND_NORMAL;
            r_tag2       <= r_tag1;
            r_tag3       <= n_tag3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1a2  <= n_a1a2;
            r_b1b2  <= n_b1b2;
            r_a2b1  <= n_a2b1;
            r_a1b2  <= n_a1b2;
            r_cross <= n_cross;
            r_dot   <= n_dot;
            r_xm    <= n_xm;
            r_ym    <= n_ym;
        end
    end

    assign o_tag   = r_tag3;
    assign o_x_mag = r_xm;
    assign o_y_mag = r_ym;

endmodule

`default_nettype wire

// File: hdl/lpa_norm_cell.sv
// lpa_norm_cell: one step of the leading-zero search, shifts both words left
// by SHIFT when the top SHIFT bits of both are clear; depends on lpa_pkg
`default_nettype none

module lpa_norm_cell #(
    parameter int NW    = 32,
    parameter int SHIFT = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire lpa_pkg::t_tag i_tag,
    input  wire logic [NW-1:0] i_x,
    input  wire logic [NW-1:0] i_y,
    output lpa_pkg::t_tag      o_tag,
    output logic      [NW-1:0] o_x,
    output logic      [NW-1:0] o_y
);

    logic          n_zero_top;
    logic [NW-1:0] n_x, n_y, r_x, r_y;
    lpa_pkg::t_tag r_tag;

    assign n_zero_top = ~|(i_x[NW-1 -: SHIFT] | i_y[NW-1 -: SHIFT]);
    assign n_x = n_zero_top ? (i_x << SHIFT) : i_x;
    assign n_y = n_zero_top ? (i_y << SHIFT) : i_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    assign o_tag = r_tag;
    assign o_x   = r_x;
    assign o_y   = r_y;

endmodule

`default_nettype wire

// File: hdl/lpa_cordic_cell.sv
// lpa_cordic_cell: one vectoring rotation of the cordic chain, step IDX
// depends on lpa_pkg for widths and the arctangent table
`default_nettype none

module lpa_cordic_cell #(
    parameter int IDX = 0
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_en,
    input  wire lpa_pkg::t_tag                    i_tag,
    input  wire logic signed [lpa_pkg::CX_W-1:0]  i_x,
    input  wire logic signed [lpa_pkg::CX_W-1:0]  i_y,
    input  wire logic signed [lpa_pkg::Z_W-1:0]   i_z,
    output lpa_pkg::t_tag                         o_tag,
    output logic signed      [lpa_pkg::CX_W-1:0]  o_x,
    output logic signed      [lpa_pkg::CX_W-1:0]  o_y,
    output logic signed      [lpa_pkg::Z_W-1:0]   o_z
);

    localparam int ZW = lpa_pkg::Z_W;
    localparam logic signed [ZW-1:0] STEP_ANG = ZW'(lpa_pkg::atan_deg(5'(IDX)));

    logic signed [lpa_pkg::CX_W-1:0] n_xs, n_ys, n_x, n_y, r_x, r_y;
    logic signed [ZW-1:0]            n_z, r_z;
    logic                            n_pos;
    lpa_pkg::t_tag                   r_tag;

    assign n_xs  = i_x >>> IDX;
    assign n_ys  = i_y >>> IDX;
    assign n_pos = ~i_y[lpa_pkg::CX_W-1];

    // rotate toward the x axis, accumulate the angle taken
    assign n_x = n_pos ? (i_x + n_ys) : (i_x - n_ys);
    assign n_y = n_pos ? (i_y - n_xs) : (i_y + n_xs);
    assign n_z = n_pos ? (i_z + STEP_ANG) : (i_z - STEP_ANG);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_tag = r_tag;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

`default_nettype wire

// File: hdl/line_pair_angle.sv
// line_pair_angle: acute angle between two lines a*x + b*y + c = 0
//
// Input channel: i_valid / o_stall with the four coefficients. A transaction
// is taken at a rising edge with i_valid high and o_stall low. Output channel:
// o_valid / i_stall with o_angle_degrees (degrees * 2^FRAC_BITS, 0 to 90
// degrees) and o_status (1 when a line has both coefficients zero).
// Throughput is one transaction per cycle while o_stall is low. A transaction
// passes through the product/term stages, the leading-zero search cells and
// the row of cordic cells, then the output register, on its way to o_valid.
// When i_stall holds a result, the next result goes to a skid register and
// o_stall rises in the following cycle; the whole pipeline then holds until
// the skid register drains. o_stall never depends on i_stall in the same
// cycle. Reset clears the valid flags of every stage; nothing needs clearing
// and the block takes transactions in the first cycle after reset.
// Items carry no state between them.
`default_nettype none

module line_pair_angle #(
    parameter int COEF_WIDTH    = lpa_pkg::COEF_WIDTH_DEF,
    parameter int CORDIC_STAGES = lpa_pkg::CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = lpa_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [COEF_WIDTH-1:0]  i_first_x_coef,
    input  wire logic signed [COEF_WIDTH-1:0]  i_first_y_coef,
    input  wire logic signed [COEF_WIDTH-1:0]  i_second_x_coef,
    input  wire logic signed [COEF_WIDTH-1:0]  i_second_y_coef,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [lpa_pkg::ANGLE_W-1:0]        o_angle_degrees,
    output logic                               o_status
);

    localparam int MW    = 2 * COEF_WIDTH;
    localparam int NW    = (MW > lpa_pkg::NORM_W) ? MW : lpa_pkg::NORM_W;
    localparam int NSH   = $clog2(NW);
    localparam int AW    = lpa_pkg::ANGLE_W;
    localparam int ZW    = lpa_pkg::Z_W;
    localparam int CW    = lpa_pkg::CX_W;
    localparam int NRM   = lpa_pkg::NORM_W;
    localparam int RSH   = lpa_pkg::ANG_FRAC - FRAC_BITS;
    localparam int SUM_W = lpa_pkg::ANG_FRAC + AW;
    localparam int ZU_W  = 27;
    localparam logic [AW-1:0]        PERP_ANGLE = AW'(32'd90 << FRAC_BITS);
    localparam logic signed [ZW-1:0] Z_MAX      = ZW'(32'd90 << lpa_pkg::ANG_FRAC);
    localparam logic [SUM_W-1:0]     ROUND_HALF = SUM_W'(64'd1 << (RSH - 1));

    logic                    w_en;
    lpa_pkg::t_tag           w_ttag;
    logic [MW-1:0]           w_xm, w_ym;

    lpa_pkg::t_tag           w_ntag [NSH+1];
    logic [NW-1:0]           w_nx   [NSH+1];
    logic [NW-1:0]           w_ny   [NSH+1];

    lpa_pkg::t_tag           w_ctag [CORDIC_STAGES+1];
    logic signed [CW-1:0]    w_cx   [CORDIC_STAGES+1];
    logic signed [CW-1:0]    w_cy   [CORDIC_STAGES+1];
    logic signed [ZW-1:0]    w_cz   [CORDIC_STAGES+1];

    logic [ZU_W-1:0]         n_zc;
    logic [SUM_W-1:0]        n_sum;
    logic [AW-1:0]           n_res_angle;
    logic                    n_res_status;

    logic                    r_out_valid, n_out_valid;
    logic [AW-1:0]           r_out_angle, n_out_angle;
    logic                    r_out_status, n_out_status;
    logic                    r_skid_valid, n_skid_valid;
    logic [AW-1:0]           r_skid_angle, n_skid_angle;
    logic                    r_skid_status, n_skid_status;

    // pipeline moves whenever the skid register is empty
    assign w_en    = ~r_skid_valid;
    assign o_stall = r_skid_valid;

    lpa_terms #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_terms (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_valid         (i_valid),
        .i_first_x_coef  (i_first_x_coef),
        .i_first_y_coef  (i_first_y_coef),
        .i_second_x_coef (i_second_x_coef),
        .i_second_y_coef (i_second_y_coef),
        .o_tag           (w_ttag),
        .o_x_mag         (w_xm),
        .o_y_mag         (w_ym)
    );

    // magnitudes placed at the top of the search word
    assign w_ntag[0] = w_ttag;
    assign w_nx[0]   = NW'(w_xm) << (NW - MW);
    assign w_ny[0]   = NW'(w_ym) << (NW - MW);

    for (genvar k = 0; k < NSH; k++) begin : g_norm
        lpa_norm_cell #(
            .NW    (NW),
            .SHIFT (1 << (NSH - 1 - k))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_tag   (w_ntag[k]),
            .i_x     (w_nx[k]),
            .i_y     (w_ny[k]),
            .o_tag   (w_ntag[k+1]),
            .o_x     (w_nx[k+1]),
            .o_y     (w_ny[k+1])
        );
    end

    // top bits of the normalized word equal the truncating shift to [2^29, 2^30)
    assign w_ctag[0] = w_ntag[NSH];
    assign w_cx[0]   = $signed({{(CW - NRM){1'b0}}, w_nx[NSH][NW-1 -: NRM]});
    assign w_cy[0]   = $signed({{(CW - NRM){1'b0}}, w_ny[NSH][NW-1 -: NRM]});
    assign w_cz[0]   = '0;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        lpa_cordic_cell #(
            .IDX (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_tag   (w_ctag[i]),
            .i_x     (w_cx[i]),
            .i_y     (w_cy[i]),
            .i_z     (w_cz[i]),
            .o_tag   (w_ctag[i+1]),
            .o_x     (w_cx[i+1]),
            .o_y     (w_cy[i+1]),
            .o_z     (w_cz[i+1])
        );
    end

    // clamp to [0, 90 deg] and round half up to the output fraction
    always_comb begin
        if (w_cz[CORDIC_STAGES][ZW-1]) begin
            n_zc = '0;
        end else if (w_cz[CORDIC_STAGES] > Z_MAX) begin
            n_zc = ZU_W'(Z_MAX);
        end else begin
            n_zc = ZU_W'(w_cz[CORDIC_STAGES]);
        end
    end

    assign n_sum = SUM_W'(n_zc) + ROUND_HALF;

    always_comb begin
        case (w_ctag[CORDIC_STAGES].kind)
            lpa_pkg::KIND_DEGEN: begin
                n_res_angle  = '0;
                n_res_status = 1'b1;
            end
            lpa_pkg::KIND_PARALLEL: begin
                n_res_angle  = '0;
                n_res_status = 1'b0;
            end
            lpa_pkg::KIND_PERP: begin
                n_res_angle  = PERP_ANGLE;
                n_res_status = 1'b0;
            end
            default: begin
                n_res_angle  = n_sum[RSH +: AW];
                n_res_status = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_angle   = r_out_angle;
        n_out_status  = r_out_status;
        n_skid_valid  = r_skid_valid;
        n_skid_angle  = r_skid_angle;
        n_skid_status = r_skid_status;
        if (r_skid_valid) begin
            if (!i_stall) begin
                n_out_angle  = r_skid_angle;
                n_out_status = r_skid_status;
                n_skid_valid = 1'b0;
            end
        end else if (!r_out_valid || !i_stall) begin
            n_out_valid  = w_ctag[CORDIC_STAGES].valid;
            n_out_angle  = n_res_angle;
            n_out_status = n_res_status;
        end else if (w_ctag[CORDIC_STAGES].valid) begin
            // output held: park the arriving result
            n_skid_valid  = 1'b1;
            n_skid_angle  = n_res_angle;
            n_skid_status = n_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_angle   <= n_out_angle;
        r_out_status  <= n_out_status;
        r_skid_angle  <= n_skid_angle;
        r_skid_status <= n_skid_status;
    end

    assign o_valid         = r_out_valid;
    assign o_angle_degrees = r_out_angle;
    assign o_status        = r_out_status;

    a_status_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_angle_degrees == '0))
        else $error("degenerate line reported with nonzero angle");

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result ahead of the output register");

    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid register filled while output was free");

    // ninety degrees fits the result field up to eight fraction bits
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (FRAC_BITS <= 8)) |-> (o_angle_degrees <= PERP_ANGLE))
        else $error("angle above ninety degrees");

endmodule

`default_nettype wire
